// File: rtl/ale_pkg.sv
package ale_pkg;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_ERASE  = 3'd1;
    localparam logic [2:0] OP_FIND   = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_SORT   = 3'd4;
    localparam logic [2:0] OP_SEARCH = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_POS  = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_WALK    = 10'b00_0000_0010,
        S_FIN     = 10'b00_0000_0100,
        S_BS_CHK  = 10'b00_0000_1000,
        S_BS_WAIT = 10'b00_0001_0000,
        S_SR_KEY  = 10'b00_0010_0000,
        S_SR_KW   = 10'b00_0100_0000,
        S_SR_CMP  = 10'b00_1000_0000,
        S_SR_PUT  = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } state_t;

endpackage

// File: rtl/ale_ram.sv
module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/array_list_engine_unit.sv
// invalid insert/erase and unused codes go straight to the result; insert, erase, find and
// remove-all stream one list entry per cycle through the ram port
// binary search reads the midpoint, then compares it, on each probe; sort is insertion sort
// one word in work at a time, the result register frees the input side
// reset: asynchronous, clears the fill count and control state; list ram is not cleared
module array_list_engine_unit #(
    parameter int LIST_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [7:0]  position,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [6:0]  index_found,
    output logic [7:0]  removed_count,
    output logic [7:0]  count_after
);
    import ale_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int PW = ((CW > 8) ? CW : 8) + 1;
    localparam int XW = CW + 8;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] rmv_reg, rmv_next;
    logic [AW-1:0] ra_reg, ra_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic          rv_reg, rv_next;
    logic          found_reg, found_next;
    logic [2:0]    op_reg, op_next;
    logic [31:0]   val_reg, val_next;
    logic [31:0]   key_reg, key_next;
    logic [1:0]    st_reg, st_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    status_reg, status_next;
    logic [6:0]    index_reg, index_next;
    logic [7:0]    removed_reg, removed_next;
    logic [7:0]    count_reg, count_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;

    logic [PW-1:0] pos_w, cnt_w;
    logic [CW:0]   mid_sum;
    logic [XW-1:0] idx_x, rmv_x, cnt_x;

    ale_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pos_w   = PW'(position);
    assign cnt_w   = PW'(cnt_reg);
    assign mid_sum = (CW+1)'(lo_reg) + (CW+1)'(hi_reg);
    assign idx_x   = XW'(idx_reg);
    assign rmv_x   = XW'(rmv_reg);
    assign cnt_x   = XW'(cnt_reg);

    // streamed walks never read an address written in the same cycle, so no forwarding
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        rem_next       = rem_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        rmv_next       = rmv_reg;
        ra_next        = ra_reg;
        mid_next       = mid_reg;
        rv_next        = 1'b0;
        found_next     = found_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        key_next       = key_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        index_next     = index_reg;
        removed_next   = removed_reg;
        count_next     = count_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = operation;
                    val_next = value;
                    st_next  = ST_OK;
                    idx_next = '0;
                    rmv_next = '0;
                    case (operation)
                        OP_INSERT:
                        begin
                            if (cnt_reg == DEPTH_C)
                            begin
                                st_next    = ST_FULL;
                                state_next = S_DONE;
                            end
                            else if (pos_w == '0 || pos_w > cnt_w + PW'(1))
                            begin
                                st_next    = ST_POS;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                pos_next   = CW'(pos_w);
                                ptr_next   = cnt_reg - CW'(1);
                                rem_next   = CW'(cnt_w + PW'(1) - pos_w);
                                state_next = S_WALK;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (pos_w == '0 || pos_w > cnt_w)
                            begin
                                st_next    = ST_POS;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ptr_next   = CW'(pos_w);
                                rem_next   = CW'(cnt_w - pos_w);
                                state_next = S_WALK;
                            end
                        end
                        OP_FIND:
                        begin
                            st_next    = ST_MISS;
                            found_next = 1'b0;
                            ptr_next   = '0;
                            rem_next   = cnt_reg;
                            state_next = S_WALK;
                        end
                        OP_REMOVE:
                        begin
                            k_next     = '0;
                            ptr_next   = '0;
                            rem_next   = cnt_reg;
                            state_next = S_WALK;
                        end
                        OP_SORT:
                        begin
                            i_next     = CW'(1);
                            state_next = S_SR_KEY;
                        end
                        OP_SEARCH:
                        begin
                            st_next    = ST_MISS;
                            lo_next    = '0;
                            hi_next    = cnt_reg;
                            state_next = S_BS_CHK;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                if (rem_reg != '0)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg[AW-1:0];
                    rv_next   = 1'b1;
                    ra_next   = ptr_reg[AW-1:0];
                    rem_next  = rem_reg - CW'(1);
                    ptr_next  = (op_reg == OP_INSERT) ? ptr_reg - CW'(1) : ptr_reg + CW'(1);
                end
                if (rv_reg)
                begin
                    case (op_reg)
                        OP_INSERT:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = ra_reg + AW'(1);
                            ram_wdata = ram_rdata;
                        end
                        OP_ERASE:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = ra_reg - AW'(1);
                            ram_wdata = ram_rdata;
                        end
                        OP_FIND:
                        begin
                            if (!found_reg && ram_rdata == val_reg)
                            begin
                                found_next = 1'b1;
                                idx_next   = CW'(ra_reg);
                                st_next    = ST_OK;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (ram_rdata != val_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = k_reg[AW-1:0];
                                ram_wdata = ram_rdata;
                                k_next    = k_reg + CW'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (rem_reg == '0 && !rv_reg)
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = AW'(pos_reg - CW'(1));
                        ram_wdata = val_reg;
                        cnt_next  = cnt_reg + CW'(1);
                    end
                    OP_ERASE:
                    begin
                        cnt_next = cnt_reg - CW'(1);
                    end
                    OP_REMOVE:
                    begin
                        rmv_next = cnt_reg - k_reg;
                        cnt_next = k_reg;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = S_DONE;
            end

            S_BS_CHK:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_sum[AW:1];
                    ram_re     = 1'b1;
                    ram_raddr  = mid_sum[AW:1];
                    state_next = S_BS_WAIT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_BS_WAIT:
            begin
                if ($signed(ram_rdata) < $signed(val_reg))
                begin
                    lo_next    = CW'(mid_reg) + CW'(1);
                    state_next = S_BS_CHK;
                end
                else if ($signed(ram_rdata) > $signed(val_reg))
                begin
                    hi_next    = CW'(mid_reg);
                    state_next = S_BS_CHK;
                end
                else
                begin
                    st_next    = ST_OK;
                    idx_next   = CW'(mid_reg);
                    state_next = S_DONE;
                end
            end

            S_SR_KEY:
            begin
                if (i_reg >= cnt_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = i_reg[AW-1:0];
                    j_next     = i_reg;
                    state_next = S_SR_KW;
                end
            end

            S_SR_KW:
            begin
                key_next   = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = AW'(j_reg - CW'(1));
                state_next = S_SR_CMP;
            end

            S_SR_CMP:
            begin
                // entry j-1 is on the read port; shift it up or drop the key in at j
                if ($signed(ram_rdata) > $signed(key_reg))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = j_reg[AW-1:0];
                    ram_wdata = ram_rdata;
                    j_next    = j_reg - CW'(1);
                    if (j_reg > CW'(1))
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(j_reg - CW'(2));
                    end
                    else
                    begin
                        state_next = S_SR_PUT;
                    end
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = j_reg[AW-1:0];
                    ram_wdata  = key_reg;
                    i_next     = i_reg + CW'(1);
                    state_next = S_SR_KEY;
                end
            end

            S_SR_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = j_reg[AW-1:0];
                ram_wdata  = key_reg;
                i_next     = i_reg + CW'(1);
                state_next = S_SR_KEY;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    index_next     = (st_reg == ST_OK) ? idx_x[6:0] : 7'd0;
                    removed_next   = rmv_x[7:0];
                    count_next     = cnt_x[7:0];
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        rem_reg     <= rem_next;
        k_reg       <= k_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        rmv_reg     <= rmv_next;
        ra_reg      <= ra_next;
        mid_reg     <= mid_next;
        found_reg   <= found_next;
        op_reg      <= op_next;
        val_reg     <= val_next;
        key_reg     <= key_next;
        st_reg      <= st_next;
        status_reg  <= status_next;
        index_reg   <= index_next;
        removed_reg <= removed_next;
        count_reg   <= count_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign index_found   = index_reg;
    assign removed_count = removed_reg;
    assign count_after   = count_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("fill count above depth");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("ram read and write to same entry");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && op_reg == OP_INSERT) |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("insert did not grow the list");

endmodule
